### rtl/slpa_pkg.sv
// Package for the strip/list primitive assembler.
// Holds shared widths, queue sizing and the vertex transaction type.
// No dependencies.
`default_nettype none

package slpa_pkg;

  // Field widths
  localparam int unsigned RefW   = 16;
  localparam int unsigned BaseW  = 21;
  localparam int unsigned IdxW   = 22;
  localparam int unsigned PosW   = 16;

  // Stream bus widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned OutPadW  = OutDataW - 3 * IdxW;

  // Decoupling queue sizing (depth must be a power of two)
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  // Strip position counter: after the last code it restarts at the first emitting slot
  localparam logic [PosW-1:0] PosLast    = {PosW{1'b1}};
  localparam logic [PosW-1:0] PosRestart = PosW'(2);
  localparam logic [PosW-1:0] PosFirstTri = PosW'(2);

  // Classified vertex moving from front to back
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            ok;
    logic            start;
    logic            list;
  } vtx_entry_t;

endpackage

`default_nettype wire

### rtl/slpa_front.sv
// Front end of the strip/list primitive assembler: accepts vertex transactions,
// adds the configured base and builds queue entries. Uses slpa_pkg.
`default_nettype none

module slpa_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [slpa_pkg::BaseW-1:0]     cfg_wdata_i,
  input  wire logic                           s_valid_i,
  output logic                                s_ready_o,
  input  wire logic [slpa_pkg::InDataW-1:0]   s_data_i,
  input  wire logic [slpa_pkg::InUserW-1:0]   s_user_i,
  input  wire logic                           q_full_i,
  output logic                                q_push_o,
  output slpa_pkg::vtx_entry_t                q_entry_o
);

  logic [slpa_pkg::BaseW-1:0] index_base_q;

  // Base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_base_q <= '0;
    end else if (cfg_we_i) begin
      index_base_q <= cfg_wdata_i;
    end
  end

  // Accept while the queue has room
  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

  // Rebase the reference and unpack the flags
  always_comb begin
    q_entry_o.idx   = {1'b0, index_base_q}
                    + {{(slpa_pkg::IdxW - slpa_pkg::RefW){1'b0}}, s_data_i};
    q_entry_o.ok    = s_user_i[0];
    q_entry_o.start = s_user_i[1];
    q_entry_o.list  = s_user_i[2];
  end

endmodule

`default_nettype wire

### rtl/slpa_fifo.sv
// Short queue decoupling front and back of the primitive assembler.
// Register-based, depth from slpa_pkg::FifoDepth. Uses slpa_pkg.
`default_nettype none

module slpa_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire slpa_pkg::vtx_entry_t  push_entry_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       valid_o,
  output slpa_pkg::vtx_entry_t       head_o
);

  slpa_pkg::vtx_entry_t              mem_q [slpa_pkg::FifoDepth];
  logic [slpa_pkg::FifoPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [slpa_pkg::FifoCntW-1:0]     count_q, count_d;
  logic                              do_push, do_pop;

  assign full_o  = (count_q == slpa_pkg::FifoCntW'(slpa_pkg::FifoDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= slpa_pkg::FifoCntW'(slpa_pkg::FifoDepth))
    else $error("queue count beyond depth");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[slpa_pkg::FifoPtrW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

### rtl/slpa_back.sv
// Back end of the primitive assembler: two-vertex window, position counter,
// winding swap and the result register. Uses slpa_pkg.
`default_nettype none

module slpa_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  wire slpa_pkg::vtx_entry_t           q_head_i,
  output logic                                q_pop_o,
  output logic                                m_valid_o,
  input  wire logic                           m_ready_i,
  output logic [slpa_pkg::OutDataW-1:0]       m_data_o
);

  localparam int unsigned IdxW = slpa_pkg::IdxW;
  localparam int unsigned PosW = slpa_pkg::PosW;

  logic [IdxW-1:0] older_idx_q, newer_idx_q;
  logic            older_ok_q, newer_ok_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            list_q;

  logic [IdxW-1:0] older_idx_s, newer_idx_s;
  logic            older_ok_s, newer_ok_s, list_s;
  logic [PosW-1:0] pos_s;

  logic            out_valid_q, out_valid_d;
  logic [IdxW-1:0] corner_a_q, corner_b_q, corner_c_q;
  logic [IdxW-1:0] corner_b_d, corner_c_d;
  logic            tri_closes, tri_ok, adv, take;

  assign take    = out_valid_q && m_ready_i;
  assign adv     = q_valid_i && (!out_valid_q || m_ready_i);
  assign q_pop_o = adv;

  // Strip start clears the window before this vertex is used
  always_comb begin
    older_idx_s = q_head_i.start ? '0 : older_idx_q;
    older_ok_s  = q_head_i.start ? 1'b0 : older_ok_q;
    newer_idx_s = q_head_i.start ? '0 : newer_idx_q;
    newer_ok_s  = q_head_i.start ? 1'b0 : newer_ok_q;
    pos_s       = q_head_i.start ? '0 : pos_q;
    list_s      = q_head_i.start ? q_head_i.list : list_q;
  end

  // Triangle close, winding and next position
  always_comb begin
    tri_closes = (pos_s >= slpa_pkg::PosFirstTri);
    corner_b_d = newer_idx_s;
    corner_c_d = q_head_i.idx;
    if (list_s) begin
      pos_d = tri_closes ? '0 : pos_s + 1'b1;
    end else begin
      if (pos_s[0]) begin
        corner_b_d = q_head_i.idx;
        corner_c_d = newer_idx_s;
      end
      pos_d = (pos_s == slpa_pkg::PosLast) ? slpa_pkg::PosRestart : pos_s + 1'b1;
    end
    tri_ok      = tri_closes && older_ok_s && newer_ok_s && q_head_i.ok;
    out_valid_d = adv ? tri_ok : (out_valid_q && !take);
  end

  // Window state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_idx_q <= '0;
      older_ok_q  <= 1'b0;
      newer_idx_q <= '0;
      newer_ok_q  <= 1'b0;
      pos_q       <= '0;
      list_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (adv) begin
        older_idx_q <= newer_idx_s;
        older_ok_q  <= newer_ok_s;
        newer_idx_q <= q_head_i.idx;
        newer_ok_q  <= q_head_i.ok;
        pos_q       <= pos_d;
        list_q      <= list_s;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (adv && tri_ok) begin
      corner_a_q <= older_idx_s;
      corner_b_q <= corner_b_d;
      corner_c_q <= corner_c_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {{slpa_pkg::OutPadW{1'b0}}, corner_c_q, corner_b_q, corner_a_q};

`ifndef SYNTHESIS
  a_list_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_q |-> (pos_q <= slpa_pkg::PosFirstTri))
    else $error("list position out of range");
  a_strip_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !q_head_i.start && !list_q && (pos_q >= slpa_pkg::PosFirstTri))
      |=> (pos_q >= slpa_pkg::PosFirstTri))
    else $error("strip position fell back without a strip start");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv))
    else $error("result raised without a processed vertex");
`endif

endmodule

`default_nettype wire

### rtl/strip_list_primitive_assembler.sv
// Strip/list primitive assembler top level: rebases vertex references and
// emits list or strip triangles. Uses slpa_pkg, slpa_front, slpa_fifo, slpa_back.
// Throughput: one vertex per clock, paused while an offered result is not taken.
// A triangle is offered from the result register once its closing vertex leaves the queue.
// A four-entry queue lets the input keep flowing while a result waits to be taken.
// Reset (asynchronous, active low) clears the base, window, counter, queue and result valid.
`default_nettype none

module strip_list_primitive_assembler (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [slpa_pkg::BaseW-1:0]     cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [slpa_pkg::InDataW-1:0]   s_axis_tdata,   // vertex_ref
  input  wire logic [slpa_pkg::InUserW-1:0]   s_axis_tuser,   // ref_valid, strip_start, list_mode
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [slpa_pkg::OutDataW-1:0]       m_axis_tdata    // corner_a, corner_b, corner_c, pad
);

  slpa_pkg::vtx_entry_t push_entry, head_entry;
  logic                 q_full, q_push, q_pop, q_valid;

  slpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  slpa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (head_entry)
  );

  slpa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (head_entry),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### test/tb_strip_list_primitive_assembler.sv
`timescale 1ns / 100ps
// Testbench for strip_list_primitive_assembler: drives strip and list vertex transactions,
// predicts the list and strip triangles and checks each output transaction in order.
// Depends on slpa_pkg and the assembler RTL.

module tb_strip_list_primitive_assembler;

  localparam int unsigned IdxW     = slpa_pkg::IdxW;
  localparam int unsigned BaseW    = slpa_pkg::BaseW;
  localparam int unsigned RefW     = slpa_pkg::RefW;
  localparam int unsigned PosW     = slpa_pkg::PosW;
  localparam int unsigned OutDataW = slpa_pkg::OutDataW;
  localparam int unsigned InDataW  = slpa_pkg::InDataW;
  localparam int unsigned InUserW  = slpa_pkg::InUserW;
  localparam logic [PosW-1:0] PosFirstTri = slpa_pkg::PosFirstTri;
  localparam logic [PosW-1:0] PosLast     = slpa_pkg::PosLast;
  localparam logic [PosW-1:0] PosRestart  = slpa_pkg::PosRestart;

  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseItems   = 120;
  localparam int unsigned NumPhases    = 5;

  typedef struct packed {
    logic [IdxW-1:0] a;
    logic [IdxW-1:0] b;
    logic [IdxW-1:0] c;
  } triangle_t;

  // Triangle predictor and store of the triangles still owed by the block
  class triangle_scoreboard;
    logic [BaseW-1:0] base         = '0;
    logic [IdxW:0]    older        = '0;  // {usable, index}
    logic [IdxW:0]    newer        = '0;
    logic [PosW-1:0]  pos          = '0;
    bit               latched_list = 1'b0;
    triangle_t        pending[$];
    int unsigned      errors       = 0;

    function void set_base(logic [BaseW-1:0] value);
      base = value;
    endfunction

    // Called for every accepted input transaction
    function void note_vertex(logic [RefW-1:0] vref, bit ok, bit start, bit list_flag);
      logic [IdxW:0] cur;
      logic [IdxW:0] a;
      logic [IdxW:0] b;
      logic [IdxW:0] c;
      logic [IdxW:0] t;
      triangle_t     tri_out;
      bit            emit;
      emit = 1'b0;
      a = '0;
      b = '0;
      c = '0;
      // a strip start clears the window and latches the mode
      if (start) begin
        older = '0;
        newer = '0;
        pos = '0;
        latched_list = list_flag;
      end
      cur = {ok, IdxW'(base) + IdxW'(vref)};
      if (pos >= PosFirstTri) begin
        a = older;
        b = newer;
        c = cur;
        emit = 1'b1;
        // odd strip triangles swap the last two corners to keep the winding
        if (!latched_list && pos[0]) begin
          t = b;
          b = c;
          c = t;
        end
      end
      if (latched_list) begin
        pos = emit ? '0 : pos + 1'b1;
      end else begin
        pos = (pos == PosLast) ? PosRestart : pos + 1'b1;
      end
      older = newer;
      newer = cur;
      // triangles with an unusable corner are skipped
      if (emit && a[IdxW] && b[IdxW] && c[IdxW]) begin
        tri_out.a = a[IdxW-1:0];
        tri_out.b = b[IdxW-1:0];
        tri_out.c = c[IdxW-1:0];
        pending = {pending, tri_out};
      end
    endfunction

    // Called for every accepted output transaction
    function void check_triangle(logic [OutDataW-1:0] data);
      triangle_t got;
      triangle_t want;
      got.a = data[IdxW-1:0];
      got.b = data[2*IdxW-1:IdxW];
      got.c = data[3*IdxW-1:2*IdxW];
      if (pending.size() == 0) begin
        $error("unexpected triangle %0h %0h %0h", got.a, got.b, got.c);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.a !== want.a) begin
        $error("corner_a: expected %0h, actual %0h", want.a, got.a);
        errors++;
      end
      if (got.b !== want.b) begin
        $error("corner_b: expected %0h, actual %0h", want.b, got.b);
        errors++;
      end
      if (got.c !== want.c) begin
        $error("corner_c: expected %0h, actual %0h", want.c, got.c);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [BaseW-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // vertex_ref
  logic [InUserW-1:0]  s_axis_tuser  = '0;   // ref_valid, strip_start, list_mode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // corner_a, corner_b, corner_c, pad

  triangle_scoreboard sb;
  bit                 rx_hold_req = 1'b0;
  bit                 tx_quiet    = 1'b0;
  int unsigned        cycle_count = 0;

  strip_list_primitive_assembler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Idle lengths: mostly short, now and then long
  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_gap();
    if (tx_quiet || $urandom_range(0, 1) == 0) return 0;
    return pick_stall();
  endfunction

  function automatic logic [RefW-1:0] pick_ref();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return RefW'($urandom);
    endcase
  endfunction

  // One input transaction, optionally after an idle gap
  task automatic send_vertex(input logic [RefW-1:0] vref, input bit ok, input bit start,
                             input bit list_flag, input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= vref;
    s_axis_tuser  <= {list_flag, start, ok};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_vertex(vref, ok, start, list_flag);
  endtask

  task automatic write_base(input logic [BaseW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_base(value);
  endtask

  // Stop offering and wait for every owed triangle, then let the pipeline settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed strips and lists with random content, some broken ones
  task automatic run_strips(input int unsigned n_items, input bit with_hold);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    bit          as_list;
    bit          hold_done;
    sent = 0;
    hold_done = !with_hold;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      as_list = $urandom_range(0, 1);
      tx_quiet = ($urandom_range(0, 3) == 0);
      if (kind < 7) begin
        len = as_list ? 3 * $urandom_range(1, 6) : $urandom_range(3, 20);
      end else begin
        len = $urandom_range(1, 8);
      end
      // long receiver hold while the sender keeps offering back to back
      if (!hold_done && sent >= n_items / 3) begin
        rx_hold_req = 1'b1;
        tx_quiet = 1'b1;
        hold_done = 1'b1;
        kind = 0;
        len = 40;
      end
      for (int i = 0; i < len; i++) begin
        send_vertex(pick_ref(), $urandom_range(0, 15) != 0, (i == 0) && (kind != 9),
                    (i == 0) ? as_list : 1'($urandom_range(0, 1)), pick_gap());
      end
      sent += len;
    end
    tx_quiet = 1'b0;
  endtask

  // Receiver: random ready with bursts and stalls, a long hold on request
  initial begin : receiver
    int unsigned span;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        span = HoldCycles;
      end else if ($urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        span = $urandom_range(1, 12);
      end else begin
        m_axis_tready <= 1'b0;
        span = pick_stall();
      end
      repeat (span) @(posedge clk_i);
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_triangle(m_axis_tdata);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [BaseW-1:0] phase_base [NumPhases];
    sb = new();
    phase_base[0] = '1;
    phase_base[1] = '0;
    phase_base[2] = BaseW'($urandom);
    phase_base[3] = BaseW'(21'h100000);
    phase_base[4] = BaseW'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no strip start after reset: runs as a strip, the list flag is ignored
    send_vertex('0, 1'b1, 1'b0, 1'b1, pick_gap());
    send_vertex('1, 1'b1, 1'b0, 1'b1, pick_gap());
    send_vertex(16'd1, 1'b1, 1'b0, 1'b0, pick_gap());
    send_vertex(16'd2, 1'b1, 1'b0, 1'b1, pick_gap());
    // list with the mode flag toggling after the start; the seventh vertex is dropped
    send_vertex(16'd10, 1'b1, 1'b1, 1'b1, pick_gap());
    send_vertex('1, 1'b1, 1'b0, 1'b0, pick_gap());
    send_vertex(16'd12, 1'b1, 1'b0, 1'b0, pick_gap());
    send_vertex('0, 1'b1, 1'b0, 1'b1, pick_gap());
    send_vertex(16'd14, 1'b1, 1'b0, 1'b0, pick_gap());
    send_vertex(16'd15, 1'b1, 1'b0, 1'b0, pick_gap());
    send_vertex(16'd16, 1'b1, 1'b0, 1'b1, pick_gap());
    // strip with an unusable vertex: three triangles skipped, window still moves
    send_vertex(16'd20, 1'b1, 1'b1, 1'b0, pick_gap());
    send_vertex(16'd21, 1'b1, 1'b0, 1'b1, pick_gap());
    send_vertex(16'd22, 1'b0, 1'b0, 1'b0, pick_gap());
    send_vertex(16'd23, 1'b1, 1'b0, 1'b0, pick_gap());
    send_vertex(16'd24, 1'b1, 1'b0, 1'b0, pick_gap());
    send_vertex(16'd25, 1'b1, 1'b0, 1'b0, pick_gap());
    // list triangle with an unusable middle corner
    send_vertex(16'd30, 1'b1, 1'b1, 1'b1, pick_gap());
    send_vertex(16'd31, 1'b0, 1'b0, 1'b1, pick_gap());
    send_vertex(16'd32, 1'b1, 1'b0, 1'b1, pick_gap());
    wait_drained();

    // random phases over several base settings, extremes included
    for (int p = 0; p < NumPhases; p++) begin
      write_base(phase_base[p]);
      run_strips(PhaseItems, p == 2);
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
